// ----- rtl/core/star_polygon_vertex_generator_unit_macros.svh -----
// Assertion helpers; clk and arst_n are taken from the enclosing module.
`ifndef STAR_POLYGON_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define STAR_POLYGON_VERTEX_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPVG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SPVG_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SPVG_ASSERT(lbl, prop, msg)
`define SPVG_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/core/spvg_pkg.sv -----
`default_nettype none
package spvg_pkg;
	localparam logic [23:0] QUARTER_TURN = 24'h400000;
	localparam logic [16:0] ONE_FACTOR = 17'h10000;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [23:0] w;
		logic [23:0] h;
		logic [16:0] fv;
		logic [5:0] idx;
		logic last;
	} meta_t;

	// round(2^24 / count), halves up
	function automatic logic [23:0] step_for(input logic [6:0] c);
		logic [23:0] r;
		r = '0;
		case (c)
			7'd3: r = 24'd5592405;
			7'd6: r = 24'd2796203;
			7'd8: r = 24'd2097152;
			7'd10: r = 24'd1677722;
			7'd12: r = 24'd1398101;
			7'd14: r = 24'd1198373;
			7'd16: r = 24'd1048576;
			7'd18: r = 24'd932068;
			7'd20: r = 24'd838861;
			7'd22: r = 24'd762601;
			7'd24: r = 24'd699051;
			7'd26: r = 24'd645278;
			7'd28: r = 24'd599186;
			7'd30: r = 24'd559241;
			7'd32: r = 24'd524288;
			7'd34: r = 24'd493448;
			7'd36: r = 24'd466034;
			7'd38: r = 24'd441506;
			7'd40: r = 24'd419430;
			7'd42: r = 24'd399458;
			7'd44: r = 24'd381300;
			7'd46: r = 24'd364722;
			7'd48: r = 24'd349525;
			7'd50: r = 24'd335544;
			7'd52: r = 24'd322639;
			7'd54: r = 24'd310689;
			7'd56: r = 24'd299593;
			7'd58: r = 24'd289262;
			7'd60: r = 24'd279620;
			7'd62: r = 24'd270600;
			7'd64: r = 24'd262144;
			default: r = '0;
		endcase
		return r;
	endfunction

	// atan(2^-i) in 2^-32 turn
	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] r;
		r = '0;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/star_polygon_vertex_generator_unit.sv -----
`default_nettype none
`include "star_polygon_vertex_generator_unit_macros.svh"
// Star polygon vertex generator. Each request transaction (center, size, point
// count N, inner factor) yields 2N vertex transactions (3 when N < 3; N is
// capped at MAX_SIDES), starting a quarter turn up and stepping by one turn over
// the vertex count. Even vertices sit on the factor-scaled ellipse, odd ones on
// the full one. A sequencer issues one vertex per cycle into a CORDIC pipeline
// of CORDIC_STEPS rotation stages behind an angle-fold register, followed by
// three placement stages (scale, multiply, round/offset/saturate); the last of
// these is the output register. A request keeps the sequencer busy until its
// last vertex is issued, so a new request is taken only after that. A stall on
// the vertex channel freezes the whole pipeline, sequencer included.
module star_polygon_vertex_generator_unit import spvg_pkg::*; #(
	parameter int MAX_SIDES = 32,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic signed [23:0] center_x,
	input wire logic signed [23:0] center_y,
	input wire logic [23:0] rect_width,
	input wire logic [23:0] rect_height,
	input wire logic [5:0] side_count,
	input wire logic signed [17:0] inner_factor,
	output logic vtx_valid,
	input wire logic vtx_stall,
	output logic signed [23:0] vertex_x,
	output logic signed [23:0] vertex_y,
	output logic [5:0] vertex_index,
	output logic last_vertex
);
	logic adv;
	logic iss_valid, cor_valid;
	logic [23:0] iss_phase;
	meta_t iss_meta, cor_meta;
	logic signed [33:0] cos_v, sin_v;

	// pipeline moves whenever the output register is empty or being drained
	assign adv = !vtx_valid || !vtx_stall;

	spvg_seq #(.MAX_SIDES(MAX_SIDES)) u_seq (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.req_valid(req_valid), .req_stall(req_stall),
		.center_x(center_x), .center_y(center_y),
		.rect_width(rect_width), .rect_height(rect_height),
		.side_count(side_count), .inner_factor(inner_factor),
		.issue_valid(iss_valid), .issue_phase(iss_phase), .issue_meta(iss_meta)
	);

	spvg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(iss_valid), .phase(iss_phase), .in_meta(iss_meta),
		.out_valid(cor_valid), .cos_q(cos_v), .sin_q(sin_v), .out_meta(cor_meta)
	);

	spvg_place u_place (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(cor_valid), .cos_in(cos_v), .sin_in(sin_v), .in_meta(cor_meta),
		.out_valid(vtx_valid), .vx(vertex_x), .vy(vertex_y),
		.vidx(vertex_index), .vlast(last_vertex)
	);

	// the sequencer is busy in the cycle after it accepts a request
	`SPVG_ASSERT(a_req_busy, req_valid && !req_stall |=> req_stall, "sequencer not busy")
	// smallest polygon has three vertices
	`SPVG_NEVER(a_last_min, vtx_valid && last_vertex && vertex_index < 6'd2, "early last")
	// apart from the triangle, vertex counts are even
	`SPVG_NEVER(a_last_odd, vtx_valid && last_vertex && vertex_index != 6'd2
		&& !vertex_index[0], "bad last index")
endmodule
`default_nettype wire

// ----- rtl/core/spvg_seq.sv -----
`default_nettype none
module spvg_seq import spvg_pkg::*; #(
	parameter int MAX_SIDES = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic signed [23:0] center_x,
	input wire logic signed [23:0] center_y,
	input wire logic [23:0] rect_width,
	input wire logic [23:0] rect_height,
	input wire logic [5:0] side_count,
	input wire logic signed [17:0] inner_factor,
	output logic issue_valid,
	output logic [23:0] issue_phase,
	output meta_t issue_meta
);
	logic busy_q;
	logic [5:0] idx_q;
	logic [6:0] total_q;
	logic [23:0] phase_q, step_q;
	logic [16:0] fac_q;
	logic signed [23:0] cx_q, cy_q;
	logic [23:0] w_q, h_q;
	logic [5:0] n_cl;
	logic [6:0] count;
	logic [16:0] f_cl;
	logic last;

	always_comb begin
		n_cl = (side_count > 6'(MAX_SIDES)) ? 6'(MAX_SIDES) : side_count;
		count = (n_cl < 6'd3) ? 7'd3 : {n_cl, 1'b0};
		if (inner_factor[17]) f_cl = '0;
		else if (inner_factor > 18'sd65536) f_cl = ONE_FACTOR;
		else f_cl = inner_factor[16:0];
		last = ({1'b0, idx_q} + 7'd1) == total_q;
	end

	assign req_stall = busy_q;
	assign issue_valid = busy_q;
	assign issue_phase = phase_q;
	assign issue_meta = '{cx: cx_q, cy: cy_q, w: w_q, h: h_q,
		fv: idx_q[0] ? ONE_FACTOR : fac_q, idx: idx_q, last: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			total_q <= '0;
			phase_q <= QUARTER_TURN;
			step_q <= '0;
		end else if (!busy_q) begin
			if (req_valid) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				total_q <= count;
				phase_q <= QUARTER_TURN;
				step_q <= step_for(count);
			end
		end else if (adv) begin
			idx_q <= idx_q + 6'd1;
			phase_q <= phase_q + step_q;
			if (last) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req_valid) begin
			cx_q <= center_x;
			cy_q <= center_y;
			w_q <= rect_width;
			h_q <= rect_height;
			fac_q <= f_cl;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/spvg_cordic.sv -----
`default_nettype none
module spvg_cordic import spvg_pkg::*; #(
	parameter int STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire logic [23:0] phase,
	input wire meta_t in_meta,
	output logic out_valid,
	output logic signed [33:0] cos_q,
	output logic signed [33:0] sin_q,
	output meta_t out_meta
);
	logic v_s [0:STEPS];
	logic flip_s [0:STEPS];
	logic signed [33:0] x_s [0:STEPS];
	logic signed [33:0] y_s [0:STEPS];
	logic signed [33:0] z_s [0:STEPS];
	meta_t m_s [0:STEPS];
	logic signed [33:0] z_in;

	// fold angle into [-quarter, +quarter] turn
	assign z_in = 34'(signed'({phase, 8'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (adv) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			m_s[0] <= in_meta;
			if (z_in > 34'sh40000000) begin
				z_s[0] <= z_in - 34'sh80000000;
				flip_s[0] <= 1'b1;
			end else if (z_in < -34'sh40000000) begin
				z_s[0] <= z_in + 34'sh80000000;
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0] <= z_in;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic signed [33:0] at;
		assign at = $signed({2'b00, atan_at(5'(k))});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (adv) v_s[k+1] <= v_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				m_s[k+1] <= m_s[k];
				flip_s[k+1] <= flip_s[k];
				if (!z_s[k][33]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - at;
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + at;
				end
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign cos_q = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign sin_q = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	assign out_meta = m_s[STEPS];
endmodule
`default_nettype wire

// ----- rtl/core/spvg_place.sv -----
`default_nettype none
module spvg_place import spvg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire logic signed [33:0] cos_in,
	input wire logic signed [33:0] sin_in,
	input wire meta_t in_meta,
	output logic out_valid,
	output logic signed [23:0] vx,
	output logic signed [23:0] vy,
	output logic [5:0] vidx,
	output logic vlast
);
	logic v_s1, v_s2, v_s3;
	logic [32:0] sx_s1, sy_s1;
	logic signed [33:0] c_s1, s_s1;
	meta_t m_s1, m_s2;
	logic signed [67:0] px_s2, py_s2;
	logic [40:0] wx, wy;
	logic signed [67:0] rx, ry;
	logic signed [29:0] ox, oy;

	function automatic logic signed [23:0] sat(input logic signed [29:0] v);
		logic signed [23:0] r;
		if (v > 30'sd8388607) r = 24'sh7fffff;
		else if (v < -30'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

	assign wx = 41'(in_meta.w) * 41'(in_meta.fv);
	assign wy = 41'(in_meta.h) * 41'(in_meta.fv);
	assign rx = px_s2 + 68'sh4000000000;
	assign ry = py_s2 + 68'sh4000000000;
	assign ox = 30'(signed'(rx[67:39])) + 30'(m_s2.cx);
	assign oy = 30'(signed'(ry[67:39])) + 30'(m_s2.cy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= wx[40:8];
			sy_s1 <= wy[40:8];
			c_s1 <= cos_in;
			s_s1 <= sin_in;
			m_s1 <= in_meta;
			px_s2 <= 68'($signed({1'b0, sx_s1})) * 68'(c_s1);
			py_s2 <= 68'($signed({1'b0, sy_s1})) * 68'(s_s1);
			m_s2 <= m_s1;
			vx <= sat(ox);
			vy <= sat(oy);
			vidx <= m_s2.idx;
			vlast <= m_s2.last;
		end
	end

	assign out_valid = v_s3;
endmodule
`default_nettype wire

// ----- tb/sv/star_polygon_vertex_generator_unit_test.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Vertex scoreboard: predicts the star outline for each accepted request and
// checks vertex transactions against it in order.
class star_vertex_scoreboard;
	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [5:0] idx;
		logic last;
	} vertex_t;

	vertex_t pending_vertices[$];
	int mismatch_count;

	static function longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	// rotation-mode CORDIC on a 24-bit turn fraction, cos/sin in Q2.30
	static function void rotate(logic [23:0] angle, output longint c, output longint s);
		longint z, x, y, dx, dy;
		longint atan_list[16] = '{536870912, 316933406, 167458907, 85004756,
			42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
			333772, 166886, 83443, 41722, 20861};
		bit flip;
		z = longint'($signed({angle, 8'h00}));
		flip = 0;
		x = 652032874;
		y = 0;
		if (z > 64'sh40000000) begin
			z -= 64'sh80000000; flip = 1;
		end else if (z < -64'sh40000000) begin
			z += 64'sh80000000; flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_list[i];
			end else begin
				x += dx; y -= dy; z += atan_list[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endfunction

	static function logic signed [23:0] position(longint center, longint extent,
			longint f, longint trig);
		longint scaled, v;
		scaled = (extent * f) >>> 8;
		v = center + floor_shift(scaled * trig + (64'sd1 <<< 38), 39);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function void note_request(logic signed [23:0] cx, logic signed [23:0] cy,
			logic [23:0] w, logic [23:0] h, logic [5:0] n_in, logic signed [17:0] f_in);
		longint f, n, count, fv, c, s;
		logic [23:0] angle, step;
		vertex_t v;
		f = f_in;
		if (f < 0) f = 0;
		if (f > 65536) f = 65536;
		n = n_in;
		if (n > 32) n = 32;
		count = (n < 3) ? 3 : 2 * n;
		step = ((64'd1 << 24) + count / 2) / count;
		angle = 24'h400000;
		for (int i = 0; i < count; i++) begin
			fv = (i % 2) ? 65536 : f;
			rotate(angle, c, s);
			v.x = position(cx, w, fv, c);
			v.y = position(cy, h, fv, s);
			v.idx = i;
			v.last = (i + 1 == count);
			pending_vertices.push_back(v);
			angle = angle + step;
		end
	endfunction

	function void report(string what);
		$display("mismatch: %s", what);
		mismatch_count++;
	endfunction

	function void check_vertex(logic signed [23:0] x, logic signed [23:0] y,
			logic [5:0] idx, logic last);
		vertex_t e;
		if (pending_vertices.size() == 0) begin
			report($sformatf("unexpected vertex idx %0d", idx));
			return;
		end
		e = pending_vertices.pop_front();
		if (x !== e.x) report($sformatf("vertex %0d x %0d want %0d", e.idx, x, e.x));
		if (y !== e.y) report($sformatf("vertex %0d y %0d want %0d", e.idx, y, e.y));
		if (idx !== e.idx) report($sformatf("index %0d want %0d", idx, e.idx));
		if (last !== e.last) report($sformatf("vertex %0d last %0b", e.idx, last));
	endfunction
endclass

module star_polygon_vertex_generator_unit_test;
	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	logic signed [23:0] center_x = 0, center_y = 0;
	logic [23:0] rect_width = 0, rect_height = 0;
	logic [5:0] side_count = 0;
	logic signed [17:0] inner_factor = 0;
	logic vtx_valid;
	logic vtx_stall = 0;
	logic signed [23:0] vertex_x, vertex_y;
	logic [5:0] vertex_index;
	logic last_vertex;

	star_vertex_scoreboard outline = new();
	// receiver modes: 0 random pattern, 1 long hold-off requested
	bit hold_request = 0;

	always #4 clk = ~clk;

	star_polygon_vertex_generator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.center_x(center_x), .center_y(center_y),
		.rect_width(rect_width), .rect_height(rect_height),
		.side_count(side_count), .inner_factor(inner_factor),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y),
		.vertex_index(vertex_index), .last_vertex(last_vertex)
	);

	// offers one request transaction and holds it until taken
	task automatic send_request(logic signed [23:0] cx, logic signed [23:0] cy,
			logic [23:0] w, logic [23:0] h, logic [5:0] n, logic signed [17:0] f);
		center_x <= cx;
		center_y <= cy;
		rect_width <= w;
		rect_height <= h;
		side_count <= n;
		inner_factor <= f;
		req_valid <= 1;
		do @(posedge clk); while (req_stall);
		outline.note_request(cx, cy, w, h, n, f);
		@(negedge clk);
	endtask

	task automatic send_random(bit wide);
		logic [5:0] n;
		logic signed [17:0] f;
		// mostly small counts keep the run short; some full-size stars
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
		case ($urandom_range(0, 5))
			0: f = $urandom;
			1: f = -$signed(18'($urandom_range(1, 65536)));
			2: f = $urandom_range(65536, 131071);
			default: f = $urandom_range(0, 65536);
		endcase
		if (wide)
			send_request($urandom, $urandom, $urandom, $urandom, n, f);
		else
			send_request($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000,
				$urandom_range(0, 40000), $urandom_range(0, 40000), n, f);
	endtask

	task automatic drain_outline();
		while (outline.pending_vertices.size() != 0) @(negedge clk);
	endtask

	// receiver stall pattern: bursts of stalling interleaved with free runs
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				vtx_stall <= 1;
				for (int i = 0; i < 400; i++) @(negedge clk);
				hold_request = 0;
			end
			run = $urandom_range(0, 3);
			case (run)
				0: vtx_stall <= 0;
				1: vtx_stall <= $urandom_range(0, 1);
				2: vtx_stall <= ($urandom_range(0, 7) == 0);
				default: vtx_stall <= ($urandom_range(0, 3) != 0);
			endcase
			for (int i = $urandom_range(1, 40); i > 0; i--) begin
				if (run == 1) vtx_stall <= $urandom_range(0, 1);
				@(negedge clk);
			end
		end
	end

	// every accepted vertex transaction is checked at the rising edge
	always @(posedge clk)
		if (arst_n && vtx_valid && !vtx_stall)
			outline.check_vertex(vertex_x, vertex_y, vertex_index, last_vertex);

	initial begin
		#4000000;
		$display("star_polygon_vertex_generator_unit_test failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: field extremes, clamps, few points, saturation
		send_request(0, 0, 24'd25600, 24'd25600, 6'd5, 18'sd32768);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd0, 18'sd0);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd1, -18'sd1);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd2, -18'sd131072);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd3, 18'sd65536);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd4, 18'sd65537);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd4, 18'sd131071);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd32, 18'sd40000);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd33, 18'sd40000);
		send_request(0, 0, 24'd1000, 24'd1000, 6'd63, 18'sd40000);
		send_request(24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 6'd6, 18'sd65536);
		send_request(-24'sh800000, -24'sh800000, 24'hFFFFFF, 24'hFFFFFF, 6'd6, 18'sd65536);
		send_request(24'sh7FFFFF, -24'sh800000, 24'hFFFFFF, 24'h0, 6'd2, 18'sd65535);
		send_request(-24'sh800000, 24'sh7FFFFF, 24'h0, 24'hFFFFFF, 6'd7, 18'sd1);
		send_request(24'sh555555, -24'sh2AAAAB, 24'hAAAAAA, 24'h555555, 6'd21, 18'sh15555);
		send_request(24'sd0, 24'sd0, 24'h0, 24'h0, 6'd0, 18'sd0);
		req_valid <= 0;

		// pause until the outline drains
		drain_outline();

		// long receiver hold-off while requests keep coming
		hold_request = 1;
		for (int i = 0; i < 20; i++) send_random(i % 2);

		for (int i = 0; i < 330; i++) begin
			send_random($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 5) == 0) begin
				req_valid <= 0;
				for (int g = $urandom_range(1, 60); g > 0; g--) @(negedge clk);
			end
		end
		req_valid <= 0;

		drain_outline();
		repeat (60) @(negedge clk);
		if (outline.mismatch_count == 0 && outline.pending_vertices.size() == 0)
			$display("star_polygon_vertex_generator_unit_test passed");
		else
			$display("star_polygon_vertex_generator_unit_test failed");
		$finish;
	end
endmodule

`default_nettype wire
